/* rtl/pdv_pkg.sv */
`default_nettype none

package pdv_pkg;

    // Opcodes of the command port
    localparam logic OP_LAUNCH = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Default configuration of the core
    localparam int NUM_BODIES_DEF   = 2;
    localparam int CORDIC_STEPS_DEF = 16;

    // Shared multiplier and divider widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 34;

    // Physical constants, Q16.16
    localparam logic [16:0] TIME_STEP_RST = 17'd655;
    localparam int GRAV_Q     = 642908;
    localparam int HALF_RHO_Q = 40141;

    // Angle constants, Q16.16 degrees, and CORDIC start gain, Q2.30
    localparam int ANG_W       = 28;
    localparam int DEG90       = 5898240;
    localparam int DEG180      = 11796480;
    localparam int DEG360      = 23592960;
    localparam int CORDIC_GAIN = 652032874;

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // Arctangent table in Q16.16 degrees
    function automatic logic [21:0] atan_deg(input logic [4:0] idx);
        logic [21:0] val;
        case (idx)
            5'd0:  val = 22'd2949120;
            5'd1:  val = 22'd1740967;
            5'd2:  val = 22'd919879;
            5'd3:  val = 22'd466945;
            5'd4:  val = 22'd234379;
            5'd5:  val = 22'd117304;
            5'd6:  val = 22'd58666;
            5'd7:  val = 22'd29335;
            5'd8:  val = 22'd14668;
            5'd9:  val = 22'd7334;
            5'd10: val = 22'd3667;
            5'd11: val = 22'd1833;
            5'd12: val = 22'd917;
            5'd13: val = 22'd458;
            5'd14: val = 22'd229;
            5'd15: val = 22'd115;
            5'd16: val = 22'd57;
            5'd17: val = 22'd29;
            5'd18: val = 22'd14;
            5'd19: val = 22'd7;
            5'd20: val = 22'd4;
            5'd21: val = 22'd2;
            5'd22: val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > $signed({{(PROD_W-32){1'b0}}, S32_MAX}))
            r = S32_MAX;
        else if (v < $signed({{(PROD_W-32){1'b1}}, S32_MIN}))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/pdv_mul.sv */
`default_nettype none

module pdv_mul (
    input  wire logic                                  clk,
    input  wire logic signed [pdv_pkg::MUL_W-1:0]      mul_a,
    input  wire logic signed [pdv_pkg::MUL_W-1:0]      mul_b,
    output logic signed [pdv_pkg::PROD_W-1:0]          prod
);

    logic signed [pdv_pkg::PROD_W-1:0] prod_reg;

    // Register the full signed product
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/pdv_div.sv */
`default_nettype none

module pdv_div #(
    parameter int NUM_W = pdv_pkg::DIV_NUM_W,
    parameter int DEN_W = pdv_pkg::DIV_DEN_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [NUM_W-1:0]      quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Restoring step: bring down one dividend bit and try the subtract
    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

/* rtl/pdv_cordic.sv */
`default_nettype none

module pdv_cordic #(
    parameter int CORDIC_STEPS = pdv_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [25:0]                  angle,
    output logic                                     busy,
    output logic signed [pdv_pkg::MUL_W-1:0]         cos_val,
    output logic signed [pdv_pkg::MUL_W-1:0]         sin_val
);

    localparam int STEPS = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
    localparam int AW    = pdv_pkg::ANG_W;
    localparam int VW    = pdv_pkg::MUL_W;
    localparam logic signed [AW-1:0] D90  = AW'(pdv_pkg::DEG90);
    localparam logic signed [AW-1:0] D180 = AW'(pdv_pkg::DEG180);
    localparam logic signed [AW-1:0] D360 = AW'(pdv_pkg::DEG360);

    logic                 busy_reg;
    logic [4:0]           step_reg;
    logic                 flip_reg;
    logic signed [VW-1:0] cx_reg;
    logic signed [VW-1:0] cy_reg;
    logic signed [AW-1:0] z_reg;
    logic signed [AW-1:0] wrapped;
    logic signed [AW-1:0] folded;
    logic                 flip_next;
    logic signed [AW-1:0] atan_val;

    // Wrap into (-180,180], then fold into [-90,90]
    always_comb
    begin
        wrapped = AW'(angle);
        if (wrapped > D180)
            wrapped = wrapped - D360;
        else if (wrapped <= -D180)
            wrapped = wrapped + D360;
        folded    = wrapped;
        flip_next = 1'b0;
        if (wrapped > D90)
        begin
            folded    = D180 - wrapped;
            flip_next = 1'b1;
        end
        else if (wrapped < -D90)
        begin
            folded    = -D180 - wrapped;
            flip_next = 1'b1;
        end
    end

    assign atan_val = $signed({{(AW-22){1'b0}}, pdv_pkg::atan_deg(step_reg)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == 5'(STEPS - 1))
                busy_reg <= 1'b0;
        end
    end

    // One rotation per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cx_reg   <= VW'(pdv_pkg::CORDIC_GAIN);
            cy_reg   <= '0;
            z_reg    <= folded;
            flip_reg <= flip_next;
        end
        else if (busy_reg)
        begin
            if (!z_reg[AW-1])
            begin
                cx_reg <= cx_reg - (cy_reg >>> step_reg);
                cy_reg <= cy_reg + (cx_reg >>> step_reg);
                z_reg  <= z_reg - atan_val;
            end
            else
            begin
                cx_reg <= cx_reg + (cy_reg >>> step_reg);
                cy_reg <= cy_reg - (cx_reg >>> step_reg);
                z_reg  <= z_reg + atan_val;
            end
        end
    end

    assign busy    = busy_reg;
    assign cos_val = flip_reg ? -cx_reg : cx_reg;
    assign sin_val = cy_reg;

endmodule

`default_nettype wire

/* rtl/projectile_drag_verlet_step_core.sv */
`default_nettype none

// Channel      Handshake                   Payload
// command      start / busy                op, body_index, launch_height, launch_speed,
//                                          launch_angle, body_mass, body_area, body_drag_coeff
// result       result_valid (one cycle)    result_body, pos_x_out, pos_y_out, has_landed,
//                                          all_landed, last_of_tick
// config       time_step_wr_en             time_step_wr_data
//
// A launch holds busy through 3 multiplies, a wait on the 64-step drag divide
// (CORDIC beside it), then the velocities, the initial drag and the commit.
// A tick steps each flying body, adds a landing divide when one lands (skipped on a
// zero denominator), and walks every slot once for the scan and once for the beats.
// Reset clears all slots and the time step goes to 655.
// The receiver cannot stall: each result beat is shown for one cycle.

module projectile_drag_verlet_step_core #(
    parameter int NUM_BODIES   = pdv_pkg::NUM_BODIES_DEF,
    parameter int CORDIC_STEPS = pdv_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               op,
    input  wire logic               body_index,
    input  wire logic signed [31:0] launch_height,
    input  wire logic [30:0]        launch_speed,
    input  wire logic signed [25:0] launch_angle,
    input  wire logic [30:0]        body_mass,
    input  wire logic [30:0]        body_area,
    input  wire logic [30:0]        body_drag_coeff,
    input  wire logic               time_step_wr_en,
    input  wire logic [16:0]        time_step_wr_data,
    output logic                    result_valid,
    output logic                    result_body,
    output logic signed [31:0]      pos_x_out,
    output logic signed [31:0]      pos_y_out,
    output logic                    has_landed,
    output logic                    all_landed,
    output logic                    last_of_tick
);

    localparam int IDX_W = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
    localparam int MW    = pdv_pkg::MUL_W;
    localparam int PW    = pdv_pkg::PROD_W;

    typedef enum logic [24:0] {
        S_IDLE     = 25'h0000001,
        S_L_MK0    = 25'h0000002,
        S_L_MK1    = 25'h0000004,
        S_L_MK2    = 25'h0000008,
        S_L_WAIT   = 25'h0000010,
        S_L_VX     = 25'h0000020,
        S_L_VY     = 25'h0000040,
        S_L_COMMIT = 25'h0000080,
        S_A_SQ     = 25'h0000100,
        S_A_HI     = 25'h0000200,
        S_A_LO     = 25'h0000400,
        S_A_SUM    = 25'h0000800,
        S_T_SCAN   = 25'h0001000,
        S_T_AD0    = 25'h0002000,
        S_T_AD1    = 25'h0004000,
        S_T_AD2    = 25'h0008000,
        S_T_AD3    = 25'h0010000,
        S_T_V0     = 25'h0020000,
        S_T_V1     = 25'h0040000,
        S_T_LAND   = 25'h0080000,
        S_T_L1     = 25'h0100000,
        S_T_L2     = 25'h0200000,
        S_T_LW     = 25'h0400000,
        S_T_COMMIT = 25'h0800000,
        S_O_EMIT   = 25'h1000000
    } state_t;

    state_t state_reg;

    // Configuration
    logic [16:0] time_step_reg;

    // Slot state
    logic signed [31:0] px_reg [NUM_BODIES];
    logic signed [31:0] py_reg [NUM_BODIES];
    logic signed [31:0] vx_reg [NUM_BODIES];
    logic signed [31:0] vy_reg [NUM_BODIES];
    logic signed [31:0] ax_reg [NUM_BODIES];
    logic signed [31:0] ay_reg [NUM_BODIES];
    logic [31:0]        drag_reg [NUM_BODIES];
    logic [NUM_BODIES-1:0] launched_reg;
    logic [NUM_BODIES-1:0] landed_reg;

    // Sequencer control
    logic [IDX_W-1:0] slot_cnt_reg;
    logic [IDX_W-1:0] launch_slot_reg;
    logic             axis_reg;
    logic             ret_launch_reg;
    logic             land_reg;

    // Working registers
    logic signed [31:0] h_reg;
    logic [30:0]        u_reg;
    logic [30:0]        m_reg;
    logic [22:0]        khi_reg;
    logic [38:0]        klo_reg;
    logic signed [31:0] wpx_reg, wpy_reg, wvx_reg, wvy_reg, wax_reg, way_reg;
    logic [31:0]        wk_reg;
    logic signed [31:0] npx_reg, npy_reg, nax_reg, nay_reg;
    logic [15:0]        plo_reg;
    logic [63:0]        dhi_reg;
    logic signed [PW-1:0] tmp_reg;
    logic signed [63:0] p1_reg;
    logic               neg_reg;
    logic signed [31:0] landx_reg;

    // Result registers
    logic               rv_reg;
    logic               rbody_reg;
    logic signed [31:0] rx_reg;
    logic signed [31:0] ry_reg;
    logic               rland_reg;
    logic               rall_reg;
    logic               rlast_reg;

    // Shared units
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic                 div_start;
    logic [63:0]          div_num;
    logic [33:0]          div_den;
    logic                 div_busy;
    logic [63:0]          quo;
    logic                 cordic_start;
    logic                 cordic_busy;
    logic signed [MW-1:0] cos_val, sin_val;

    // Derived values
    logic               accept;
    logic               launch_ok;
    logic               last_slot;
    logic signed [31:0] cur_v;
    logic [31:0]        cur_mag;
    logic [63:0]        d_mag;
    logic signed [32:0] d_term;
    logic [63:0]        k_sum;
    logic signed [63:0] p2_val;
    logic [63:0]        land_num;
    logic signed [33:0] land_den;
    logic               land_neg;
    logic               more_after;
    logic               all_down;
    logic signed [31:0] ad_p, ad_v, ad_a, ad_na;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign launch_ok = ({31'b0, body_index} < 32'(NUM_BODIES));
    assign last_slot = (slot_cnt_reg == IDX_W'(NUM_BODIES - 1));

    pdv_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    pdv_div #(
        .NUM_W (pdv_pkg::DIV_NUM_W),
        .DEN_W (pdv_pkg::DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (quo)
    );

    pdv_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (launch_angle),
        .busy    (cordic_busy),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    assign cordic_start = accept && (op == pdv_pkg::OP_LAUNCH);

    // Select the axis being worked on
    assign cur_v = axis_reg ? wvy_reg : wvx_reg;
    assign ad_p  = axis_reg ? wpy_reg : wpx_reg;
    assign ad_v  = axis_reg ? wvy_reg : wvx_reg;
    assign ad_a  = axis_reg ? way_reg : wax_reg;
    assign ad_na = axis_reg ? nay_reg : nax_reg;
    assign cur_mag = cur_v[31] ? (~cur_v + 32'd1) : cur_v;

    // Drag magnitude and its signed term
    always_comb
    begin
        d_mag = dhi_reg + 64'(prod[PW-1:16]);
        if (cur_v[31])
            d_term = (d_mag > 64'h7fffffff) ? 33'sh07fffffff : $signed({1'b0, d_mag[31:0]});
        else if (cur_v != 32'sd0)
            d_term = (d_mag > 64'h80000000) ? -33'sh080000000 : -$signed({1'b0, d_mag[31:0]});
        else
            d_term = '0;
    end

    // Drag factor numerator before the divide
    assign k_sum = {prod[40:0], 23'b0} + {25'b0, klo_reg};

    // Landing cross products and denominator
    always_comb
    begin
        p2_val   = prod[63:0];
        land_den = 34'(npy_reg) - 34'(wpy_reg);
        land_neg = (p1_reg < p2_val);
        land_num = land_neg ? 64'(p2_val - p1_reg) : 64'(p1_reg - p2_val);
        if (land_den < 0)
            land_neg = !land_neg;
    end

    // Divider hookup
    always_comb
    begin
        div_start = 1'b0;
        div_num   = {k_sum[63:16], 16'b0};
        div_den   = {3'b0, m_reg};
        if (state_reg == S_L_MK2)
        begin
            div_start = (m_reg != 31'd0);
        end
        else if (state_reg == S_T_L2)
        begin
            div_start = (land_den != 34'sd0);
            div_num   = land_num;
            div_den   = (land_den < 0) ? 34'(-land_den) : land_den;
        end
    end

    // Shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_IDLE:
            begin
                mul_a = $signed({3'b0, body_drag_coeff});
                mul_b = $signed({3'b0, body_area});
            end
            S_L_MK0:
            begin
                mul_a = $signed({11'b0, prod[38:16]});
                mul_b = MW'(pdv_pkg::HALF_RHO_Q);
            end
            S_L_MK1:
            begin
                mul_a = $signed({11'b0, khi_reg});
                mul_b = MW'(pdv_pkg::HALF_RHO_Q);
            end
            S_L_WAIT:
            begin
                mul_a = $signed({3'b0, u_reg});
                mul_b = cos_val;
            end
            S_L_VX:
            begin
                mul_a = $signed({3'b0, u_reg});
                mul_b = sin_val;
            end
            S_A_SQ:
            begin
                mul_a = $signed({2'b0, cur_mag});
                mul_b = $signed({2'b0, cur_mag});
            end
            S_A_HI:
            begin
                mul_a = $signed({2'b0, prod[63:32]});
                mul_b = $signed({2'b0, wk_reg});
            end
            S_A_LO:
            begin
                mul_a = $signed({18'b0, plo_reg});
                mul_b = $signed({2'b0, wk_reg});
            end
            S_T_AD0:
            begin
                mul_a = MW'(ad_a);
                mul_b = $signed({17'b0, time_step_reg});
            end
            S_T_AD1:
            begin
                mul_a = prod[MW+15:16];
                mul_b = $signed({17'b0, time_step_reg});
            end
            S_T_AD2:
            begin
                mul_a = MW'(ad_v);
                mul_b = $signed({17'b0, time_step_reg});
            end
            S_T_V0:
            begin
                mul_a = MW'(ad_a) + MW'(ad_na);
                mul_b = $signed({17'b0, time_step_reg});
            end
            S_T_LAND:
            begin
                mul_a = MW'(wpx_reg);
                mul_b = MW'(npy_reg);
            end
            S_T_L1:
            begin
                mul_a = MW'(npx_reg);
                mul_b = MW'(wpy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Flags for the result beats
    always_comb
    begin
        more_after = 1'b0;
        all_down   = 1'b1;
        for (int j = 0; j < NUM_BODIES; j++)
        begin
            if (j > int'(slot_cnt_reg) && launched_reg[j])
                more_after = 1'b1;
            if (launched_reg[j] && !landed_reg[j])
                all_down = 1'b0;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= pdv_pkg::TIME_STEP_RST;
        else if (time_step_wr_en)
            time_step_reg <= time_step_wr_data;
    end

    // Sequencer and slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slot_cnt_reg    <= '0;
            launch_slot_reg <= '0;
            axis_reg        <= 1'b0;
            ret_launch_reg  <= 1'b0;
            land_reg        <= 1'b0;
            rv_reg          <= 1'b0;
            launched_reg    <= '0;
            landed_reg      <= '0;
            for (int j = 0; j < NUM_BODIES; j++)
            begin
                px_reg[j]   <= '0;
                py_reg[j]   <= '0;
                vx_reg[j]   <= '0;
                vy_reg[j]   <= '0;
                ax_reg[j]   <= '0;
                ay_reg[j]   <= '0;
                drag_reg[j] <= '0;
            end
        end
        else
        begin
            rv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (op == pdv_pkg::OP_TICK)
                        begin
                            slot_cnt_reg <= '0;
                            state_reg    <= S_T_SCAN;
                        end
                        else if (launch_ok)
                        begin
                            launch_slot_reg <= IDX_W'(body_index);
                            state_reg       <= S_L_MK0;
                        end
                    end
                end
                S_L_MK0:
                    state_reg <= S_L_MK1;
                S_L_MK1:
                    state_reg <= S_L_MK2;
                S_L_MK2:
                    state_reg <= S_L_WAIT;
                S_L_WAIT:
                begin
                    if (!div_busy && !cordic_busy)
                        state_reg <= S_L_VX;
                end
                S_L_VX:
                    state_reg <= S_L_VY;
                S_L_VY:
                begin
                    axis_reg       <= 1'b0;
                    ret_launch_reg <= 1'b1;
                    state_reg      <= S_A_SQ;
                end
                S_L_COMMIT:
                begin
                    px_reg[launch_slot_reg]   <= '0;
                    py_reg[launch_slot_reg]   <= h_reg;
                    vx_reg[launch_slot_reg]   <= wvx_reg;
                    vy_reg[launch_slot_reg]   <= wvy_reg;
                    ax_reg[launch_slot_reg]   <= nax_reg;
                    ay_reg[launch_slot_reg]   <= nay_reg;
                    drag_reg[launch_slot_reg] <= wk_reg;
                    launched_reg[launch_slot_reg] <= 1'b1;
                    landed_reg[launch_slot_reg]   <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_A_SQ:
                    state_reg <= S_A_HI;
                S_A_HI:
                    state_reg <= S_A_LO;
                S_A_LO:
                    state_reg <= S_A_SUM;
                S_A_SUM:
                begin
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_A_SQ;
                    end
                    else
                    begin
                        axis_reg  <= 1'b0;
                        state_reg <= ret_launch_reg ? S_L_COMMIT : S_T_V0;
                    end
                end
                S_T_SCAN:
                begin
                    axis_reg <= 1'b0;
                    if (launched_reg[slot_cnt_reg] && !landed_reg[slot_cnt_reg])
                        state_reg <= S_T_AD0;
                    else if (last_slot)
                    begin
                        slot_cnt_reg <= '0;
                        state_reg    <= S_O_EMIT;
                    end
                    else
                        slot_cnt_reg <= slot_cnt_reg + 1'b1;
                end
                S_T_AD0:
                    state_reg <= S_T_AD1;
                S_T_AD1:
                    state_reg <= S_T_AD2;
                S_T_AD2:
                    state_reg <= S_T_AD3;
                S_T_AD3:
                begin
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_T_AD0;
                    end
                    else
                    begin
                        axis_reg       <= 1'b0;
                        ret_launch_reg <= 1'b0;
                        state_reg      <= S_A_SQ;
                    end
                end
                S_T_V0:
                    state_reg <= S_T_V1;
                S_T_V1:
                begin
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_T_V0;
                    end
                    else
                    begin
                        axis_reg  <= 1'b0;
                        state_reg <= S_T_LAND;
                    end
                end
                S_T_LAND:
                begin
                    land_reg  <= (npy_reg <= 32'sd0);
                    state_reg <= (npy_reg <= 32'sd0) ? S_T_L1 : S_T_COMMIT;
                end
                S_T_L1:
                    state_reg <= S_T_L2;
                S_T_L2:
                    state_reg <= (land_den == 34'sd0) ? S_T_COMMIT : S_T_LW;
                S_T_LW:
                begin
                    if (!div_busy)
                        state_reg <= S_T_COMMIT;
                end
                S_T_COMMIT:
                begin
                    px_reg[slot_cnt_reg] <= land_reg ? landx_reg : npx_reg;
                    py_reg[slot_cnt_reg] <= land_reg ? 32'sd0 : npy_reg;
                    vx_reg[slot_cnt_reg] <= wvx_reg;
                    vy_reg[slot_cnt_reg] <= wvy_reg;
                    ax_reg[slot_cnt_reg] <= nax_reg;
                    ay_reg[slot_cnt_reg] <= nay_reg;
                    if (land_reg)
                        landed_reg[slot_cnt_reg] <= 1'b1;
                    if (last_slot)
                    begin
                        slot_cnt_reg <= '0;
                        state_reg    <= S_O_EMIT;
                    end
                    else
                    begin
                        slot_cnt_reg <= slot_cnt_reg + 1'b1;
                        state_reg    <= S_T_SCAN;
                    end
                end
                S_O_EMIT:
                begin
                    rv_reg <= launched_reg[slot_cnt_reg];
                    if (last_slot)
                    begin
                        slot_cnt_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                    else
                        slot_cnt_reg <= slot_cnt_reg + 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Working registers of the datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                h_reg <= launch_height;
                u_reg <= launch_speed;
                m_reg <= body_mass;
            end
            S_L_MK0:
                khi_reg <= prod[61:39];
            S_L_MK1:
                klo_reg <= prod[38:0];
            S_L_WAIT:
            begin
                if (m_reg == 31'd0 || quo[63:31] != '0)
                    wk_reg <= 32'h7fffffff;
                else
                    wk_reg <= quo[31:0];
            end
            S_L_VX:
                wvx_reg <= pdv_pkg::sat32(prod >>> 30);
            S_L_VY:
                wvy_reg <= pdv_pkg::sat32(prod >>> 30);
            S_A_HI:
                plo_reg <= prod[31:16];
            S_A_LO:
                dhi_reg <= prod[63:0];
            S_A_SUM:
            begin
                if (!axis_reg)
                    nax_reg <= d_term[31:0];
                else
                    nay_reg <= pdv_pkg::sat32(PW'(d_term) - PW'(pdv_pkg::GRAV_Q));
            end
            S_T_SCAN:
            begin
                wpx_reg <= px_reg[slot_cnt_reg];
                wpy_reg <= py_reg[slot_cnt_reg];
                wvx_reg <= vx_reg[slot_cnt_reg];
                wvy_reg <= vy_reg[slot_cnt_reg];
                wax_reg <= ax_reg[slot_cnt_reg];
                way_reg <= ay_reg[slot_cnt_reg];
                wk_reg  <= drag_reg[slot_cnt_reg];
            end
            S_T_AD2:
                tmp_reg <= prod >>> 17;
            S_T_AD3:
            begin
                if (!axis_reg)
                    npx_reg <= pdv_pkg::sat32(PW'(ad_p) + (prod >>> 16) + tmp_reg);
                else
                    npy_reg <= pdv_pkg::sat32(PW'(ad_p) + (prod >>> 16) + tmp_reg);
            end
            S_T_V1:
            begin
                if (!axis_reg)
                    wvx_reg <= pdv_pkg::sat32(PW'(wvx_reg) + (prod >>> 17));
                else
                    wvy_reg <= pdv_pkg::sat32(PW'(wvy_reg) + (prod >>> 17));
            end
            S_T_L1:
                p1_reg <= prod[63:0];
            S_T_L2:
            begin
                neg_reg   <= land_neg;
                landx_reg <= npx_reg;
            end
            S_T_LW:
            begin
                if (neg_reg)
                    landx_reg <= (quo[63:31] != '0) ? pdv_pkg::S32_MIN : -$signed(quo[31:0]);
                else
                    landx_reg <= (quo[63:31] != '0) ? pdv_pkg::S32_MAX : $signed(quo[31:0]);
            end
            S_O_EMIT:
            begin
                rbody_reg <= slot_cnt_reg[0];
                rx_reg    <= px_reg[slot_cnt_reg];
                ry_reg    <= py_reg[slot_cnt_reg];
                rland_reg <= landed_reg[slot_cnt_reg];
                rall_reg  <= all_down;
                rlast_reg <= !more_after;
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = rv_reg;
    assign result_body  = rbody_reg;
    assign pos_x_out    = rx_reg;
    assign pos_y_out    = ry_reg;
    assign has_landed   = rland_reg;
    assign all_landed   = rall_reg;
    assign last_of_tick = rlast_reg;

    // A result beat only follows a cycle of the emit walk
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_O_EMIT))
        else $error("result beat outside the emit walk");

    // A launch never produces a result beat
    a_launch_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == pdv_pkg::OP_LAUNCH) |=> !result_valid)
        else $error("result beat after a launch");

    // The divider is only started when idle
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // The CORDIC is idle by the time velocities are formed
    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_L_VX) |-> !cordic_busy)
        else $error("velocity formed before the rotation finished");

endmodule

`default_nettype wire
